@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL modules.
// Each macro checks one implication at the rising clock edge, disabled in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define PGFS_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication: cons must hold in the cycle after ante.
`define PGFS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

@@ rtl/pgfs_pkg.sv @@
// ----------------------------------------------------------------------------
// pgfs_pkg
// Types, constants and the prime table of the process grid factor split.
// ----------------------------------------------------------------------------
`default_nettype none

package pgfs_pkg;

  localparam int FIELD_W     = 16;
  localparam int COUNT_BITS  = 16;
  localparam int SIZE_BITS   = 16;
  localparam int PRIME_COUNT = 12;

  localparam int PRIME_W   = 6;
  localparam int PIDX_W    = (PRIME_COUNT > 1) ? $clog2(PRIME_COUNT) : 1;
  localparam int STEP_W    = $clog2(COUNT_BITS + 1);
  localparam int SIDX_W    = $clog2(COUNT_BITS);
  localparam int DIV_RADIX = 4;
  localparam int DIV_STEPS = (COUNT_BITS + DIV_RADIX - 1) / DIV_RADIX;
  localparam int DIV_W     = DIV_STEPS * DIV_RADIX;
  localparam int DCNT_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;
  localparam int PROD_W    = SIZE_BITS + COUNT_BITS;

  localparam logic [PRIME_W-1:0] PRIMES [12] = '{
    6'd2, 6'd3, 6'd5, 6'd7, 6'd11, 6'd13, 6'd17, 6'd19, 6'd23, 6'd29, 6'd31, 6'd37
  };

  typedef struct packed {
    logic [FIELD_W-1:0] proc_count;
    logic [FIELD_W-1:0] size_x;
    logic [FIELD_W-1:0] size_y;
    logic [FIELD_W-1:0] size_z;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] procs_x;
    logic [FIELD_W-1:0] procs_y;
    logic [FIELD_W-1:0] procs_z;
  } out_item_t;

  typedef enum logic [1:0] {
    AXIS_X,
    AXIS_Y,
    AXIS_Z
  } axis_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_TRIAL,
    S_DIV,
    S_COFAC,
    S_PICK,
    S_MUL,
    S_CMP,
    S_APPLY,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic trial_commit;
    logic cofac;
    logic pick;
    logic mul;
    logic cmp;
    logic apply;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic trial_end;
    logic div_done;
    logic has_factor;
    logic last_axis;
  } dp_status_t;

  function automatic logic [PRIME_W-1:0] prime_of(input logic [PIDX_W-1:0] idx);
    return PRIMES[int'(idx)];
  endfunction

endpackage

`default_nettype wire

@@ rtl/pgfs_div.sv @@
// ----------------------------------------------------------------------------
// pgfs_div
// Radix-16 restoring divider of the remaining count by a small prime.
// ----------------------------------------------------------------------------
`default_nettype none

module pgfs_div (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic [pgfs_pkg::COUNT_BITS-1:0]   dividend,
  input  wire logic [pgfs_pkg::PRIME_W-1:0]      divisor,
  output logic                                   done,
  output logic [pgfs_pkg::COUNT_BITS-1:0]        quotient,
  output logic [pgfs_pkg::PRIME_W-1:0]           remainder
);

  logic                              busy_r;
  logic                              done_r;
  logic [pgfs_pkg::DCNT_W-1:0]       cnt_r;
  logic [pgfs_pkg::DIV_W-1:0]        q_r;
  logic [pgfs_pkg::PRIME_W-1:0]      rem_r;
  logic [pgfs_pkg::PRIME_W-1:0]      dsr_r;

  logic [pgfs_pkg::DIV_W-1:0]        q_nxt;
  logic [pgfs_pkg::PRIME_W-1:0]      rem_nxt;
  logic [pgfs_pkg::PRIME_W:0]        rem_ext;

  // Four quotient bits per cycle; the remainder stays below the prime.
  always_comb begin
    q_nxt   = q_r;
    rem_nxt = rem_r;
    rem_ext = '0;
    for (int k = 0; k < pgfs_pkg::DIV_RADIX; k++) begin
      rem_ext = {rem_nxt, q_nxt[pgfs_pkg::DIV_W-1]};
      q_nxt   = {q_nxt[pgfs_pkg::DIV_W-2:0], 1'b0};
      if (rem_ext >= {1'b0, dsr_r}) begin
        rem_ext  = rem_ext - {1'b0, dsr_r};
        q_nxt[0] = 1'b1;
      end
      rem_nxt = rem_ext[pgfs_pkg::PRIME_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == pgfs_pkg::DCNT_W'(pgfs_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= pgfs_pkg::DIV_W'(dividend);
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = q_r[pgfs_pkg::COUNT_BITS-1:0];
  assign remainder = rem_r;

endmodule

`default_nettype wire

@@ rtl/pgfs_datapath.sv @@
// ----------------------------------------------------------------------------
// pgfs_datapath
// Trial division, factor stack and greedy ratio assignment registers.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pgfs_datapath (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire pgfs_pkg::ctrl_cmd_t  cmd,
  input  wire pgfs_pkg::in_item_t   in_data,
  output pgfs_pkg::dp_status_t      status,
  output pgfs_pkg::out_item_t       out_data
);

  localparam int CB = pgfs_pkg::COUNT_BITS;
  localparam int SB = pgfs_pkg::SIZE_BITS;

  function automatic logic [pgfs_pkg::STEP_W-1:0] bit_len(input logic [CB-1:0] v);
    logic [pgfs_pkg::STEP_W-1:0] n;
    n = '0;
    for (int k = 0; k < CB; k++) begin
      if (v[k]) n = pgfs_pkg::STEP_W'(k + 1);
    end
    return n;
  endfunction

  // control state
  logic [pgfs_pkg::STEP_W-1:0]  steps_r;
  logic [pgfs_pkg::PIDX_W-1:0]  pi_r;
  logic                         pout_r;
  logic [pgfs_pkg::STEP_W-1:0]  stk_cnt_r;
  logic                         cof_vld_r;
  pgfs_pkg::axis_t              axis_r;
  pgfs_pkg::axis_t              best_r;

  // payload
  logic [CB-1:0]                rest_r;
  logic [pgfs_pkg::PIDX_W-1:0]  stk_r [CB];
  logic [CB-1:0]                fac_r;
  logic [SB-1:0]                size_x_r, size_y_r, size_z_r;
  logic                         axes3_r;
  logic [CB-1:0]                procs_x_r, procs_y_r, procs_z_r;
  logic [SB-1:0]                bnum_r;
  logic [CB-1:0]                bden_r;
  logic [pgfs_pkg::PROD_W-1:0]  prod_a_r, prod_b_r;
  pgfs_pkg::out_item_t          out_r;

  logic                         div_done;
  logic [CB-1:0]                div_quot;
  logic [pgfs_pkg::PRIME_W-1:0] div_rem;
  logic [CB-1:0]                rest_in;
  logic [pgfs_pkg::STEP_W-1:0]  top_cnt;
  logic [SB-1:0]                size_sel;
  logic [CB-1:0]                procs_sel;
  logic [CB-1:0]                procs_best;
  logic [2*CB-1:0]              procs_prod;
  logic                         found;

  pgfs_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (rest_r),
    .divisor   (pgfs_pkg::prime_of(pi_r)),
    .done      (div_done),
    .quotient  (div_quot),
    .remainder (div_rem)
  );

  assign rest_in    = CB'(in_data.proc_count);
  assign top_cnt    = stk_cnt_r - pgfs_pkg::STEP_W'(1);
  assign found      = (div_rem == '0);
  assign procs_prod = (2*CB)'(procs_best) * (2*CB)'(fac_r);

  always_comb begin
    case (axis_r)
      pgfs_pkg::AXIS_X: begin
        size_sel  = size_x_r;
        procs_sel = procs_x_r;
      end
      pgfs_pkg::AXIS_Y: begin
        size_sel  = size_y_r;
        procs_sel = procs_y_r;
      end
      pgfs_pkg::AXIS_Z: begin
        size_sel  = size_z_r;
        procs_sel = procs_z_r;
      end
      default: begin
        size_sel  = size_x_r;
        procs_sel = procs_x_r;
      end
    endcase
  end

  always_comb begin
    case (best_r)
      pgfs_pkg::AXIS_X: procs_best = procs_x_r;
      pgfs_pkg::AXIS_Y: procs_best = procs_y_r;
      pgfs_pkg::AXIS_Z: procs_best = procs_z_r;
      default:          procs_best = procs_x_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      steps_r   <= '0;
      pi_r      <= '0;
      pout_r    <= 1'b0;
      stk_cnt_r <= '0;
      cof_vld_r <= 1'b0;
      axis_r    <= pgfs_pkg::AXIS_X;
      best_r    <= pgfs_pkg::AXIS_X;
    end else begin
      if (cmd.load) begin
        steps_r   <= bit_len(rest_in);
        pi_r      <= '0;
        pout_r    <= 1'b0;
        stk_cnt_r <= '0;
        cof_vld_r <= 1'b0;
      end
      if (cmd.trial_commit) begin
        steps_r <= steps_r - 1'b1;
        if (found) begin
          stk_cnt_r <= stk_cnt_r + 1'b1;
        end else if (pi_r == pgfs_pkg::PIDX_W'(pgfs_pkg::PRIME_COUNT - 1)) begin
          pout_r <= 1'b1;
        end else begin
          pi_r <= pi_r + 1'b1;
        end
      end
      if (cmd.cofac) begin
        cof_vld_r <= (rest_r > CB'(1));
      end
      if (cmd.pick) begin
        // leftover cofactor is never below any prime found, so it goes first
        if (cof_vld_r) cof_vld_r <= 1'b0;
        else           stk_cnt_r <= top_cnt;
        axis_r <= pgfs_pkg::AXIS_X;
        best_r <= pgfs_pkg::AXIS_X;
      end
      if (cmd.cmp) begin
        axis_r <= pgfs_pkg::axis_t'(axis_r + 2'd1);
        if (prod_a_r > prod_b_r) best_r <= axis_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rest_r    <= rest_in;
      size_x_r  <= SB'(in_data.size_x);
      size_y_r  <= SB'(in_data.size_y);
      size_z_r  <= SB'(in_data.size_z);
      axes3_r   <= (SB'(in_data.size_z) != '0);
      procs_x_r <= CB'(1);
      procs_y_r <= CB'(1);
      procs_z_r <= CB'(1);
    end
    if (cmd.trial_commit && found) begin
      stk_r[stk_cnt_r[pgfs_pkg::SIDX_W-1:0]] <= pi_r;
      rest_r <= div_quot;
    end
    if (cmd.pick) begin
      if (cof_vld_r) fac_r <= rest_r;
      else           fac_r <= CB'(pgfs_pkg::prime_of(stk_r[top_cnt[pgfs_pkg::SIDX_W-1:0]]));
      bnum_r <= '0;
      bden_r <= CB'(1);
    end
    if (cmd.mul) begin
      prod_a_r <= pgfs_pkg::PROD_W'(size_sel) * pgfs_pkg::PROD_W'(bden_r);
      prod_b_r <= pgfs_pkg::PROD_W'(bnum_r) * pgfs_pkg::PROD_W'(procs_sel);
    end
    if (cmd.cmp && (prod_a_r > prod_b_r)) begin
      bnum_r <= size_sel;
      bden_r <= procs_sel;
    end
    if (cmd.apply) begin
      case (best_r)
        pgfs_pkg::AXIS_X: procs_x_r <= procs_prod[CB-1:0];
        pgfs_pkg::AXIS_Y: procs_y_r <= procs_prod[CB-1:0];
        pgfs_pkg::AXIS_Z: procs_z_r <= procs_prod[CB-1:0];
        default:          procs_x_r <= procs_prod[CB-1:0];
      endcase
    end
    if (cmd.out_load) begin
      out_r.procs_x <= pgfs_pkg::FIELD_W'(procs_x_r);
      out_r.procs_y <= pgfs_pkg::FIELD_W'(procs_y_r);
      out_r.procs_z <= axes3_r ? pgfs_pkg::FIELD_W'(procs_z_r) : pgfs_pkg::FIELD_W'(1);
    end
  end

  assign status.trial_end  = (steps_r == '0) || pout_r;
  assign status.div_done   = div_done;
  assign status.has_factor = cof_vld_r || (stk_cnt_r != '0);
  assign status.last_axis  = (axis_r == (axes3_r ? pgfs_pkg::AXIS_Z : pgfs_pkg::AXIS_Y));
  assign out_data          = out_r;

  `PGFS_ASSERT_IMPL(a_push_room, clk, rst_n, cmd.trial_commit && found, stk_cnt_r < pgfs_pkg::STEP_W'(CB))

endmodule

`default_nettype wire

@@ rtl/pgfs_ctrl.sv @@
// ----------------------------------------------------------------------------
// pgfs_ctrl
// Sequencer: trial division steps, cofactor, greedy assignment, result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module pgfs_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  input  wire pgfs_pkg::dp_status_t  status,
  output pgfs_pkg::ctrl_cmd_t        cmd
);

  pgfs_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pgfs_pkg::S_IDLE:  if (in_valid) state_nxt = pgfs_pkg::S_TRIAL;
      pgfs_pkg::S_TRIAL: state_nxt = status.trial_end ? pgfs_pkg::S_COFAC : pgfs_pkg::S_DIV;
      pgfs_pkg::S_DIV:   if (status.div_done) state_nxt = pgfs_pkg::S_TRIAL;
      pgfs_pkg::S_COFAC: state_nxt = pgfs_pkg::S_PICK;
      pgfs_pkg::S_PICK:  state_nxt = status.has_factor ? pgfs_pkg::S_MUL : pgfs_pkg::S_DONE;
      pgfs_pkg::S_MUL:   state_nxt = pgfs_pkg::S_CMP;
      pgfs_pkg::S_CMP:   state_nxt = status.last_axis ? pgfs_pkg::S_APPLY : pgfs_pkg::S_MUL;
      pgfs_pkg::S_APPLY: state_nxt = pgfs_pkg::S_PICK;
      pgfs_pkg::S_DONE:  if (out_free) state_nxt = pgfs_pkg::S_IDLE;
      default:           state_nxt = pgfs_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      pgfs_pkg::S_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      pgfs_pkg::S_TRIAL: cmd.div_start    = !status.trial_end;
      pgfs_pkg::S_DIV:   cmd.trial_commit = status.div_done;
      pgfs_pkg::S_COFAC: cmd.cofac        = 1'b1;
      pgfs_pkg::S_PICK:  cmd.pick         = status.has_factor;
      pgfs_pkg::S_MUL:   cmd.mul          = 1'b1;
      pgfs_pkg::S_CMP:   cmd.cmp          = 1'b1;
      pgfs_pkg::S_APPLY: cmd.apply        = 1'b1;
      pgfs_pkg::S_DONE:  cmd.out_load     = out_free;
      default:           cmd              = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)    out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pgfs_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  `PGFS_ASSERT_IMPL(a_load_into_free_slot, clk, rst_n, cmd.out_load, !out_valid_r || !out_stall)
  `PGFS_ASSERT_NEXT(a_accept_starts_trial, clk, rst_n, in_valid && (state_r == pgfs_pkg::S_IDLE), state_r == pgfs_pkg::S_TRIAL)
  `PGFS_ASSERT_IMPL(a_div_done_in_wait, clk, rst_n, status.div_done, state_r == pgfs_pkg::S_DIV)

endmodule

`default_nettype wire

@@ rtl/process_grid_factor_split.sv @@
// Sequence: trial-division steps (bit length of proc_count steps at most), then per
//   factor one multiply and one compare per axis of the 3D or 2D grid, then the
//   hand-off of the result through the output register.
// Throughput: one transaction at a time; a new input is taken only in the idle state.
// Reset: synchronous active-low rst_n clears the sequencer and the output valid.
// ----------------------------------------------------------------------------
// process_grid_factor_split
// Splits a process count over the axes of a 2D or 3D grid by greedy ratio.
// ----------------------------------------------------------------------------
`default_nettype none

module process_grid_factor_split (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire pgfs_pkg::in_item_t   in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output pgfs_pkg::out_item_t       out_data
);

  pgfs_pkg::ctrl_cmd_t  cmd;
  pgfs_pkg::dp_status_t status;

  pgfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  pgfs_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .status   (status),
    .out_data (out_data)
  );

endmodule

`default_nettype wire
